// ===== design/pbc_pkg.sv =====
// proximity beep cadence: shared widths, constants, register codes and stage types
// no dependencies; imported by every module of the block

package pbc_pkg;

  localparam int unsigned WidthW   = 16;
  localparam int unsigned NowW     = 32;
  localparam int unsigned DistW    = 18;
  localparam int unsigned TenthsW  = 14;
  localparam int unsigned WaitW    = 15;
  localparam int unsigned CfgIdxW  = 4;
  localparam int unsigned CfgDataW = 16;

  localparam int unsigned DistProdW = WidthW + 9;
  localparam int unsigned DistShift = 6;
  localparam int unsigned WaitProdW = TenthsW + 22;
  localparam int unsigned WaitShift = 20;

  localparam logic [WidthW-1:0]   ECHO_TIMEOUT_US = 16'd30000;
  localparam logic [8:0]          DIST_MUL        = 9'd281;
  localparam logic [DistW-1:0]    DIST_MAX        = 18'd262143;
  // 14 * ceil(2^20 / 5): scale by 14 and divide by 5 in one constant product
  localparam logic [21:0]         WAIT_MUL        = 22'd2936024;
  localparam logic [WaitW-1:0]    WAIT_BASE       = 15'd40;

  localparam logic [15:0] THRESHOLD_RESET = 16'd2560;
  localparam logic [15:0] ON_TIME_RESET   = 16'd60;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ALERT_THRESHOLD = 4'd0,
    CFG_BEEP_ON_TIME    = 4'd1
  } cfg_idx_e;

  typedef struct packed {
    logic [15:0] alert_threshold;
    logic [15:0] beep_on_time;
  } cfg_t;

  typedef struct packed {
    logic [WidthW-1:0] echo_width;
    logic [NowW-1:0]   now_ms;
  } echo_t;

  typedef struct packed {
    logic              measured;
    logic [DistW-1:0]  distance;
    logic [NowW-1:0]   now_ms;
  } dist_t;

  typedef struct packed {
    logic              measured;
    logic [DistW-1:0]  distance;
    logic [WaitW-1:0]  wait_ms;
    logic [NowW-1:0]   now_ms;
  } wait_t;

  typedef struct packed {
    logic             measured;
    logic [DistW-1:0] distance_q8;
    logic             in_alert;
    logic             buzzer;
  } result_t;

endpackage

// ===== design/pbc_if.sv =====
// proximity beep cadence: valid/ready channel interfaces for echo, result and config
// depends on pbc_pkg for field widths

interface pbc_echo_if;
  import pbc_pkg::*;
  logic              valid;
  logic              ready;
  logic [WidthW-1:0] echo_width;
  logic [NowW-1:0]   now_ms;
  modport source (output valid, output echo_width, output now_ms, input ready);
  modport sink   (input valid, input echo_width, input now_ms, output ready);
endinterface

interface pbc_result_if;
  import pbc_pkg::*;
  logic             valid;
  logic             ready;
  logic             measured;
  logic [DistW-1:0] distance_q8;
  logic             in_alert;
  logic             buzzer;
  modport source (output valid, output measured, output distance_q8, output in_alert,
                  output buzzer, input ready);
  modport sink   (input valid, input measured, input distance_q8, input in_alert,
                  input buzzer, output ready);
endinterface

interface pbc_cfg_if;
  import pbc_pkg::*;
  logic                valid;
  logic                ready;
  logic [CfgIdxW-1:0]  index;
  logic [CfgDataW-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== design/pbc_dist.sv =====
// proximity beep cadence: input register and echo validity / distance computation
// depends on pbc_pkg

module pbc_dist
  import pbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  echo_t echo_i,
  output logic  valid_o,
  input  logic  ready_i,
  output dist_t dist_o
);

  logic                 valid_q;
  echo_t                echo_q;
  logic [DistProdW-1:0] prod;
  logic [DistW:0]       dist_raw;
  logic                 measured;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      echo_q <= echo_i;
    end
  end

  always_comb begin
    measured = (echo_q.echo_width != '0) && (echo_q.echo_width <= ECHO_TIMEOUT_US);
    prod     = DistProdW'(echo_q.echo_width) * DistProdW'(DIST_MUL);
    dist_raw = prod[DistProdW-1:DistShift];
    dist_o.measured = measured;
    dist_o.now_ms   = echo_q.now_ms;
    if (!measured) begin
      dist_o.distance = '0;
    end else if (dist_raw > {1'b0, DIST_MAX}) begin
      dist_o.distance = DIST_MAX;
    end else begin
      dist_o.distance = dist_raw[DistW-1:0];
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== design/pbc_wait.sv =====
// proximity beep cadence: distance register and off-time (wait) computation
// depends on pbc_pkg

module pbc_wait
  import pbc_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  valid_i,
  output logic  ready_o,
  input  dist_t dist_i,
  output logic  valid_o,
  input  logic  ready_i,
  output wait_t wait_o
);

  logic                 valid_q;
  dist_t                dist_q;
  logic [DistW+3:0]     dist_x10;
  logic [TenthsW-1:0]   tenths;
  logic [WaitProdW-1:0] prod;

  assign ready_o = !valid_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      dist_q <= dist_i;
    end
  end

  always_comb begin
    dist_x10 = {1'b0, dist_q.distance, 3'b000} + {3'b000, dist_q.distance, 1'b0};
    tenths   = dist_x10[DistW+3:8];
    // floor(tenths * 14 / 5) via reciprocal
    prod     = WaitProdW'(tenths) * WaitProdW'(WAIT_MUL);
    wait_o.measured = dist_q.measured;
    wait_o.distance = dist_q.distance;
    wait_o.now_ms   = dist_q.now_ms;
    wait_o.wait_ms  = WAIT_BASE + prod[WaitShift+WaitW-1:WaitShift];
  end

  assign valid_o = valid_q;

endmodule

// ===== design/pbc_cadence.sv =====
// proximity beep cadence: alert decision, buzzer toggle state and result register
// depends on pbc_pkg

module pbc_cadence
  import pbc_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  cfg_t    cfg_i,
  input  logic    valid_i,
  output logic    ready_o,
  input  wait_t   wait_i,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t result_o
);

  logic            valid_q;
  wait_t           wait_q;
  logic            out_valid_q;
  result_t         result_q;
  result_t         result_d;
  logic            active_q;
  logic            active_d;
  logic [NowW-1:0] last_q;
  logic [NowW-1:0] last_d;
  logic [NowW-1:0] elapsed;
  logic            alert;
  logic            out_free;
  logic            advance;

  assign out_free = !out_valid_q || ready_i;
  assign advance  = valid_q && out_free;
  assign ready_o  = !valid_q || out_free;

  always_comb begin
    alert    = wait_q.measured && ({2'b00, cfg_i.alert_threshold} > wait_q.distance);
    elapsed  = wait_q.now_ms - last_q;
    active_d = active_q;
    last_d   = last_q;
    if (!alert) begin
      active_d = 1'b0;
    end else if (active_q) begin
      if (elapsed >= NowW'(cfg_i.beep_on_time)) begin
        active_d = 1'b0;
        last_d   = wait_q.now_ms;
      end
    end else if (elapsed >= NowW'(wait_q.wait_ms)) begin
      active_d = 1'b1;
      last_d   = wait_q.now_ms;
    end
    result_d.measured    = wait_q.measured;
    result_d.distance_q8 = wait_q.distance;
    result_d.in_alert    = alert;
    result_d.buzzer      = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= 1'b0;
      out_valid_q <= 1'b0;
      active_q    <= 1'b0;
      last_q      <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (out_free) begin
        out_valid_q <= valid_q;
      end
      if (advance) begin
        active_q <= active_d;
        last_q   <= last_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      wait_q <= wait_i;
    end
    if (advance) begin
      result_q <= result_d;
    end
  end

  assign valid_o  = out_valid_q;
  assign result_o = result_q;

endmodule

// ===== design/proximity_beep_cadence.sv =====
// proximity beep cadence: top level with configuration registers and stage chain
// depends on pbc_pkg, pbc_if, pbc_dist, pbc_wait and pbc_cadence

// Takes one echo reading per cycle while the input is ready and returns one result
// per reading, in order. A reading passes the input, distance and wait registers
// and is then offered from the result register until it is taken. The pipeline
// holds an input register, a distance stage (constant multiply by 281), a wait
// stage (off time from the tenths value by one constant product) and a decision
// stage whose buzzer state and last-toggle time close a loop through their own
// registers, so back-to-back readings see each other's toggles exactly. A full
// result register does not stop the stages before it from filling. Configuration
// writes are taken every cycle; unknown register indexes are ignored.

module proximity_beep_cadence
  import pbc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  pbc_echo_if.sink            in_i,
  pbc_result_if.source        out_o,
  pbc_cfg_if.sink             cfg_i
);

  cfg_t    cfg_q;
  echo_t   echo;
  dist_t   dist_s;
  wait_t   wait_s;
  result_t result;
  logic    dist_valid;
  logic    dist_ready;
  logic    wait_valid;
  logic    wait_ready;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.alert_threshold <= THRESHOLD_RESET;
      cfg_q.beep_on_time    <= ON_TIME_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      unique case (cfg_idx_e'(cfg_i.index))
        CFG_ALERT_THRESHOLD: cfg_q.alert_threshold <= cfg_i.data;
        CFG_BEEP_ON_TIME:    cfg_q.beep_on_time    <= cfg_i.data;
        default: ;
      endcase
    end
  end

  assign echo.echo_width = in_i.echo_width;
  assign echo.now_ms     = in_i.now_ms;

  pbc_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .echo_i  (echo),
    .valid_o (dist_valid),
    .ready_i (dist_ready),
    .dist_o  (dist_s)
  );

  pbc_wait u_wait (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (dist_valid),
    .ready_o (dist_ready),
    .dist_i  (dist_s),
    .valid_o (wait_valid),
    .ready_i (wait_ready),
    .wait_o  (wait_s)
  );

  pbc_cadence u_cadence (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .valid_i  (wait_valid),
    .ready_o  (wait_ready),
    .wait_i   (wait_s),
    .valid_o  (out_o.valid),
    .ready_i  (out_o.ready),
    .result_o (result)
  );

  assign out_o.measured    = result.measured;
  assign out_o.distance_q8 = result.distance_q8;
  assign out_o.in_alert    = result.in_alert;
  assign out_o.buzzer      = result.buzzer;

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.buzzer |-> out_o.in_alert && out_o.measured)
    else $error("buzzer sounding outside alert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.measured |-> out_o.distance_q8 == '0 && !out_o.in_alert)
    else $error("unmeasured result carries distance or alert");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.measured
      |-> out_o.in_alert == (out_o.distance_q8 < {2'b00, cfg_q.alert_threshold}))
    else $error("alert flag disagrees with threshold");

endmodule

// ===== dv/proximity_beep_cadence_tb.sv =====
// proximity beep cadence testbench: echo readings in, one result per reading out,
// checked in order against a cycle-free model of distance, alert and buzzer cadence
// depends on pbc_pkg, the pbc_if channel interfaces and the proximity_beep_cadence top
`timescale 1ns / 1ps

module proximity_beep_cadence_tb;
  import pbc_pkg::*;

  localparam int unsigned EchoTimeoutUs = 30000;
  localparam int unsigned DistMul       = 281;
  localparam longint unsigned DistCap   = 262143;
  localparam int unsigned OffBaseMs     = 40;
  localparam logic [CfgIdxW-1:0] CfgIdxUnused = 4'd9;

  logic clk_i;
  logic rst_ni;

  pbc_echo_if   echo_if ();
  pbc_result_if res_if ();
  pbc_cfg_if    cfg_if ();

  proximity_beep_cadence uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (echo_if),
    .out_o  (res_if),
    .cfg_i  (cfg_if)
  );

  echo_t   pend_echo_q[$];
  result_t exp_res_q[$];

  logic [15:0] pred_thr;
  logic [15:0] pred_on_ms;
  logic        buzz_on;
  logic [31:0] last_toggle_ms;

  logic        src_idle_en;
  logic        snk_idle_en;
  logic [31:0] clock_ms;
  int unsigned fail_cnt;
  int unsigned results_seen;
  int unsigned src_gap;
  int unsigned snk_stall;
  int unsigned hold_cycles;

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic result_t cadence_step(input echo_t e);
    result_t         r;
    longint unsigned dist_v;
    longint unsigned off_ms;
    logic [31:0]     elapsed;
    r = '0;
    if (e.echo_width == '0 || e.echo_width > EchoTimeoutUs) begin
      buzz_on = 1'b0;
      return r;
    end
    dist_v = (64'(e.echo_width) * DistMul) >> 6;
    if (dist_v > DistCap) dist_v = DistCap;
    r.measured    = 1'b1;
    r.distance_q8 = dist_v[DistW-1:0];
    r.in_alert    = dist_v < pred_thr;
    if (r.in_alert) begin
      elapsed = e.now_ms - last_toggle_ms;
      if (buzz_on) begin
        if (elapsed >= pred_on_ms) begin
          buzz_on        = 1'b0;
          last_toggle_ms = e.now_ms;
        end
      end else begin
        off_ms = OffBaseMs + ((((dist_v * 10) >> 8) * 14) / 5);
        if (64'(elapsed) >= off_ms) begin
          buzz_on        = 1'b1;
          last_toggle_ms = e.now_ms;
        end
      end
    end else begin
      buzz_on = 1'b0;
    end
    r.buzzer = buzz_on;
    return r;
  endfunction

  // echo driver
  always @(posedge clk_i) begin : drive_echo
    echo_t nxt;
    echo_t took;
    if (!rst_ni) begin
      echo_if.valid      <= 1'b0;
      echo_if.echo_width <= '0;
      echo_if.now_ms     <= '0;
      src_gap = 0;
    end else if (!echo_if.valid || echo_if.ready) begin
      if (echo_if.valid) begin
        took.echo_width = echo_if.echo_width;
        took.now_ms     = echo_if.now_ms;
        exp_res_q.push_back(cadence_step(took));
      end
      if (src_gap == 0 && pend_echo_q.size() > 0) begin
        nxt = pend_echo_q.pop_front();
        echo_if.valid      <= 1'b1;
        echo_if.echo_width <= nxt.echo_width;
        echo_if.now_ms     <= nxt.now_ms;
        src_gap = src_idle_en ? $urandom_range(0, 16) : 0;
      end else begin
        echo_if.valid <= 1'b0;
        if (src_gap > 0) src_gap--;
      end
    end
  end

  // result monitor
  always @(posedge clk_i) begin : check_result
    result_t want;
    if (!rst_ni) begin
      res_if.ready <= 1'b0;
      snk_stall   = 0;
      hold_cycles = 0;
    end else begin
      if (res_if.valid && res_if.ready) begin
        if (exp_res_q.size() == 0) begin
          $error("result transfer with nothing expected");
          fail_cnt++;
        end else begin
          want = exp_res_q.pop_front();
          if (res_if.measured !== want.measured) begin
            $error("measured: expected %0d, got %0d", want.measured, res_if.measured);
            fail_cnt++;
          end
          if (res_if.distance_q8 !== want.distance_q8) begin
            $error("distance_q8: expected %0d, got %0d", want.distance_q8,
                   res_if.distance_q8);
            fail_cnt++;
          end
          if (res_if.in_alert !== want.in_alert) begin
            $error("in_alert: expected %0d, got %0d", want.in_alert, res_if.in_alert);
            fail_cnt++;
          end
          if (res_if.buzzer !== want.buzzer) begin
            $error("buzzer: expected %0d, got %0d", want.buzzer, res_if.buzzer);
            fail_cnt++;
          end
        end
        results_seen++;
        snk_stall = snk_idle_en ? $urandom_range(0, 16) : 0;
        // long back-pressure so the pipeline fills and stalls its input
        if (results_seen % 250 == 100) hold_cycles = 300;
      end else if (hold_cycles > 0) begin
        hold_cycles--;
      end else if (snk_stall > 0) begin
        snk_stall--;
      end
      res_if.ready <= (hold_cycles == 0 && snk_stall == 0);
    end
  end

  task automatic push_echo(input logic [15:0] w, input logic [31:0] t);
    echo_t e;
    e.echo_width = w;
    e.now_ms     = t;
    pend_echo_q.push_back(e);
  endtask

  task automatic push_random_echo();
    int unsigned r;
    int unsigned w_alert;
    int unsigned off_max;
    int unsigned span;
    logic [15:0] w;
    logic [31:0] t;
    w_alert = (int'(pred_thr) * 64) / DistMul + 1;
    if (w_alert > EchoTimeoutUs) w_alert = EchoTimeoutUs;
    off_max = OffBaseMs + ((((int'(pred_thr) * 10) >> 8) * 14) / 5);
    span = ((pred_on_ms > off_max) ? pred_on_ms : off_max) / 4 + 2;
    clock_ms += $urandom_range(0, span);
    t = clock_ms;
    r = $urandom_range(0, 99);
    if (r < 6) begin
      w = '0;
    end else if (r < 12) begin
      w = 16'($urandom);
    end else if (r < 16) begin
      w = 16'($urandom_range(EchoTimeoutUs + 1, 65535));
    end else if (r < 20) begin
      w = 16'($urandom_range(1, EchoTimeoutUs));
      t = $urandom;
    end else if (r < 40) begin
      w = 16'($urandom_range(1, EchoTimeoutUs));
    end else begin
      w = 16'($urandom_range(1, w_alert));
    end
    push_echo(w, t);
  endtask

  task automatic run_random(input int unsigned n);
    int unsigned i;
    for (i = 0; i < n; i++) begin
      if (i % 25 == 0) begin
        src_idle_en = ($urandom_range(0, 2) != 0);
        snk_idle_en = ($urandom_range(0, 2) != 0);
      end
      push_random_echo();
    end
  endtask

  // sender holds off until every expected result is back
  task automatic settle();
    while (pend_echo_q.size() != 0 || echo_if.valid || exp_res_q.size() != 0)
      @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [15:0] val);
    @(posedge clk_i);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val;
    do @(posedge clk_i); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_ALERT_THRESHOLD: pred_thr = val;
      CFG_BEEP_ON_TIME:    pred_on_ms = val;
      default: ;
    endcase
  endtask

  initial begin : stimulus
    rst_ni             = 1'b0;
    echo_if.valid      = 1'b0;
    echo_if.echo_width = '0;
    echo_if.now_ms     = '0;
    res_if.ready       = 1'b0;
    cfg_if.valid       = 1'b0;
    cfg_if.index       = '0;
    cfg_if.data        = '0;
    pred_thr           = 16'd2560;
    pred_on_ms         = 16'd60;
    buzz_on            = 1'b0;
    last_toggle_ms     = '0;
    src_idle_en        = 1'b1;
    snk_idle_en        = 1'b1;
    fail_cnt           = 0;
    results_seen       = 0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // reset settings: cadence edges, silencing, no echo, time wrap
    push_echo(16'd0, 32'd5);
    push_echo(16'd100, 32'd86);
    push_echo(16'd100, 32'd87);
    push_echo(16'd100, 32'd146);
    push_echo(16'd100, 32'd147);
    push_echo(16'd100, 32'd233);
    push_echo(16'd100, 32'd234);
    push_echo(16'd1000, 32'd240);
    push_echo(16'd30001, 32'd260);
    push_echo(16'd65535, 32'd270);
    push_echo(16'd1, 32'd400);
    push_echo(16'd583, 32'd500);
    push_echo(16'd584, 32'd900);
    push_echo(16'd30000, 32'd1000);
    push_echo(16'd582, 32'hFFFF_FFF0);
    push_echo(16'd582, 32'h0000_002B);
    push_echo(16'd582, 32'h0000_002C);
    push_echo(16'd582, 32'hFFFF_FFFF);
    push_echo(16'd0, 32'hFFFF_FFFF);
    settle();

    write_reg(CfgIdxUnused, 16'($urandom));
    write_reg(CFG_ALERT_THRESHOLD, 16'hFFFF);
    write_reg(CFG_BEEP_ON_TIME, 16'd0);
    clock_ms = 32'hFFFF_F000;
    push_echo(16'd14926, clock_ms);
    push_echo(16'd14927, clock_ms);
    run_random(130);
    settle();

    write_reg(CFG_ALERT_THRESHOLD, 16'd0);
    write_reg(CFG_BEEP_ON_TIME, 16'hFFFF);
    push_echo(16'd1, clock_ms);
    run_random(60);
    settle();

    write_reg(CFG_ALERT_THRESHOLD, 16'($urandom_range(2000, 20000)));
    write_reg(CFG_BEEP_ON_TIME, 16'($urandom_range(0, 300)));
    run_random(200);
    settle();

    // alert compare on equality: 583 us gives exactly 2559
    write_reg(CFG_ALERT_THRESHOLD, 16'd2559);
    write_reg(CFG_BEEP_ON_TIME, 16'd60);
    push_echo(16'd583, clock_ms);
    push_echo(16'd582, clock_ms + 32'd1000);
    clock_ms += 32'd1000;
    run_random(130);
    settle();

    write_reg(CFG_ALERT_THRESHOLD, 16'd2560);
    write_reg(CFG_BEEP_ON_TIME, 16'd60);
    clock_ms = $urandom;
    run_random(130);
    settle();
    repeat (20) @(posedge clk_i);

    if (fail_cnt == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
design/pbc_pkg.sv
design/pbc_if.sv
design/pbc_dist.sv
design/pbc_wait.sv
design/pbc_cadence.sv
design/proximity_beep_cadence.sv
dv/proximity_beep_cadence_tb.sv
